/* design/dtc_pkg.sv */
// -----------------------------------------------------------------------------
// dtc_pkg
// Shared widths, register indexes, the command struct that passes between the
// front, the window command queue and the back, and the output word struct.
// -----------------------------------------------------------------------------
package dtc_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 16;
	localparam int LAG_W    = 11;
	localparam int WLEN_W   = 7;
	localparam int KPOS_W   = 6;
	localparam int DIFF_W   = 17;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;
	localparam int TDATA_W  = 24;

	// Widest ring address the block supports (depth up to 65536)
	localparam int POS_W = 16;

	// Window length saturates at this many words
	localparam logic [WLEN_W-1:0] MAX_WIN = 7'd64;

	// Register reset values
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd500;
	localparam int                LAG_RESET  = 10;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd50;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_LAG       = 2'd1,
		REG_WINDOW    = 2'd2
	} cfg_reg_t;

	// One window dump request from the front to the back
	typedef struct packed {
		logic [POS_W-1:0]  base;   // ring index of window word 0
		logic [WLEN_W-1:0] win;    // words to emit, 1..64
		logic [POS_W-1:0]  wp_e;   // write position when the window was cut
		logic              full_e; // ring fully written when the window was cut
	} win_cmd_t;

	// One result word waiting at the output
	typedef struct packed {
		logic              last;
		logic [KPOS_W-1:0] pos;
		logic [SAMPLE_W-1:0] value;
	} out_word_t;

endpackage

/* design/differential_trigger_capture_top.sv */
// -----------------------------------------------------------------------------
// differential_trigger_capture_top
// Pre-trigger ring capture: stores samples, triggers on a lagged difference
// and dumps the window centred on the trigger point.
//
//   port group   dir  payload                              accepted when
//   s_*          in   tdata[15:0] sample_value             s_tvalid & s_tready
//   m_*          out  tdata[15:0] captured_value,          m_tvalid & m_tready
//                     tdata[21:16] window_position,
//                     tlast last_of_window
//   cfg_*        in   cfg_index 0 threshold, 1 lag,        cfg_we
//                     2 window length; cfg_data value
//
// One sample per cycle while s_tready is high: the front takes a word in each
// such cycle through its two stages (ring write and lag read, then difference
// and trigger). The back reads one window word per cycle from the ring's second
// read port while its output buffer has room; the ring read is registered.
// No clearing pass after reset: the ring tracks how far it has been filled
// and reads never-written entries as zero.
// s_tready drops while a cut window finds the two-entry command queue full,
// and while RING_DEPTH-128 samples have arrived since the oldest unread cut.
// -----------------------------------------------------------------------------
module differential_trigger_capture_top
	import dtc_pkg::*;
#(
	parameter int RING_DEPTH = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [15:0] sample_value
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,   // [15:0] captured_value, [21:16] window_position
	output logic                m_tlast,   // last_of_window
	// configuration
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);

	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic                ra_en;
	logic [AW-1:0]       ra_addr;
	logic [SAMPLE_W-1:0] ra_data;
	logic                rb_en;
	logic [AW-1:0]       rb_addr;
	logic [SAMPLE_W-1:0] rb_data;

	logic     cmd_push;
	win_cmd_t cmd;
	logic     q_pop;
	logic     q_valid;
	logic     q_full;
	win_cmd_t q_head;

	// Sample ring
	dtc_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.ra_en   (ra_en),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_en   (rb_en),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	// Intake and trigger
	dtc_front #(
		.RING_DEPTH(RING_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.ra_en     (ra_en),
		.ra_addr   (ra_addr),
		.ra_data   (ra_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_valid   (q_valid),
		.q_head    (q_head)
	);

	// Window commands
	dtc_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_head   (q_head)
	);

	// Window readout
	dtc_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.rb_en    (rb_en),
		.rb_addr  (rb_addr),
		.rb_data  (rb_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* design/dtc_ring.sv */
// -----------------------------------------------------------------------------
// dtc_ring
// Sample ring memory: one write port, two registered read ports (lag read for
// the front, window read for the back).
// -----------------------------------------------------------------------------
module dtc_ring
	import dtc_pkg::*;
#(
	parameter int RING_DEPTH = 8192
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	input  logic [SAMPLE_W-1:0]           wr_data,
	input  logic                          ra_en,
	input  logic [$clog2(RING_DEPTH)-1:0] ra_addr,
	output logic [SAMPLE_W-1:0]           ra_data,
	input  logic                          rb_en,
	input  logic [$clog2(RING_DEPTH)-1:0] rb_addr,
	output logic [SAMPLE_W-1:0]           rb_data
);

	logic [SAMPLE_W-1:0] ring_mem_q [RING_DEPTH];

	// Write the newest sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem_q[wr_addr] <= wr_data;
		end
	end

	// Lag read port
	always_ff @(posedge clk) begin
		if (ra_en) begin
			ra_data <= ring_mem_q[ra_addr];
		end
	end

	// Window read port
	always_ff @(posedge clk) begin
		if (rb_en) begin
			rb_data <= ring_mem_q[rb_addr];
		end
	end

endmodule

/* design/dtc_front.sv */
// -----------------------------------------------------------------------------
// dtc_front
// Sample intake: configuration registers, ring write and lag read, difference
// tracking, trigger detection and window cut decisions.
// -----------------------------------------------------------------------------
module dtc_front
	import dtc_pkg::*;
#(
	parameter int RING_DEPTH = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [SAMPLE_W-1:0]           s_tdata,
	// configuration
	input  logic                          cfg_we,
	input  logic [IDX_W-1:0]              cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	// ring write and lag read
	output logic                          wr_en,
	output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	output logic [SAMPLE_W-1:0]           wr_data,
	output logic                          ra_en,
	output logic [$clog2(RING_DEPTH)-1:0] ra_addr,
	input  logic [SAMPLE_W-1:0]           ra_data,
	// window command queue
	output logic                          cmd_push,
	output win_cmd_t                      cmd,
	input  logic                          q_full,
	input  logic                          q_valid,
	input  win_cmd_t                      q_head
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH = (AW+1)'(RING_DEPTH);
	// A window spans at most 127 entries back from its cut point; keep writes
	// out of that span until the window is read.
	localparam logic [AW:0] GUARD = (AW+1)'(RING_DEPTH - 128);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH) begin
			s = s - DEPTH;
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (s[AW]) begin
			s = s + DEPTH;
		end
		return s[AW-1:0];
	endfunction

	// Configuration
	logic [THR_W-1:0]  thr_q;
	logic [WLEN_W-1:0] wlen_q;
	logic [AW-1:0]     lag_mod_q;
	logic [19:0]       lag_red;

	// Stage 0 state
	logic [AW-1:0] wp_q;
	logic          full_q;
	logic [AW-1:0] wp_next;
	logic          full_next;
	logic [AW-1:0] lag_addr;
	logic          lag_ok;
	logic [AW-1:0] cut_gap;
	logic          guard_stall;
	logic          accept;

	// Stage 1
	logic                s1_v_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]       wpo_s1;
	logic                fullo_s1;
	logic                byp_s1;
	logic                lagok_s1;
	logic                s1_adv;

	// Trigger state
	logic [AW-1:0]       trig_q;
	logic                armed_q;
	logic [DIFF_W-1:0]   last_diff_q;
	logic                hit;
	logic [AW-1:0]       trig_eff;
	logic                armed_eff;
	logic [KPOS_W-1:0]   half;
	logic [AW-1:0]       target;
	logic                emit;
	logic [WLEN_W-1:0]   win;
	logic                need_q;
	logic [SAMPLE_W-1:0] lag_val;
	logic [DIFF_W-1:0]   diff;

	// Reduce the lag modulo the ring depth (quotient is below 16)
	always_comb begin
		lag_red = {9'd0, cfg_data[LAG_W-1:0]};
		for (int s = 3; s >= 0; s--) begin
			if (lag_red >= (20'(RING_DEPTH) << s)) begin
				lag_red = lag_red - (20'(RING_DEPTH) << s);
			end
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			wlen_q    <= WLEN_RESET;
			lag_mod_q <= AW'(LAG_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				REG_LAG:       lag_mod_q <= lag_red[AW-1:0];
				REG_WINDOW:    wlen_q    <= cfg_data[WLEN_W-1:0];
				default:       ;
			endcase
		end
	end

	// Stage 0: advance the write position, store, start the lag read
	always_comb begin
		wp_next     = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		full_next   = full_q | (wp_next == '0);
		lag_addr    = wrap_sub(wp_next, lag_mod_q);
		lag_ok      = full_next || (lag_addr != '0 && lag_addr <= wp_next);
		cut_gap     = wrap_sub(wp_q, q_head.wp_e[AW-1:0]);
		guard_stall = q_valid && ({1'b0, cut_gap} >= GUARD);
		s_tready    = !guard_stall && (!s1_v_q || s1_adv);
		accept      = s_tvalid && s_tready;
	end

	assign wr_en   = accept;
	assign wr_addr = wp_next;
	assign wr_data = s_tdata;
	assign ra_en   = accept;
	assign ra_addr = lag_addr;

	// Stage 1: trigger check on the previous difference, cut decision, new difference
	always_comb begin
		hit       = $signed({last_diff_q[DIFF_W-1], last_diff_q}) > $signed({2'b00, thr_q});
		trig_eff  = hit ? wpo_s1 : trig_q;
		armed_eff = hit | armed_q;
		half      = wlen_q[WLEN_W-1:1];
		target    = wrap_add(trig_eff, AW'(half));
		emit      = armed_eff && (wpo_s1 == target);
		win       = (wlen_q > MAX_WIN) ? MAX_WIN : wlen_q;
		need_q    = emit && (win != '0);
		s1_adv    = !(need_q && q_full);
		cmd_push  = s1_v_q && need_q && !q_full;
		lag_val   = byp_s1 ? sample_s1 : (lagok_s1 ? ra_data : '0);
		diff      = {sample_s1[SAMPLE_W-1], sample_s1} - {lag_val[SAMPLE_W-1], lag_val};
	end

	always_comb begin
		cmd.base   = POS_W'(wrap_sub(trig_eff, AW'(half)));
		cmd.win    = win;
		cmd.wp_e   = POS_W'(wpo_s1);
		cmd.full_e = fullo_s1;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			full_q      <= 1'b0;
			s1_v_q      <= 1'b0;
			trig_q      <= '0;
			armed_q     <= 1'b0;
			last_diff_q <= '0;
		end else begin
			if (accept) begin
				wp_q   <= wp_next;
				full_q <= full_next;
			end
			s1_v_q <= accept || (s1_v_q && !s1_adv);
			if (s1_v_q && s1_adv) begin
				trig_q      <= trig_eff;
				armed_q     <= armed_eff && !emit;
				last_diff_q <= diff;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_tdata;
			wpo_s1    <= wp_q;
			fullo_s1  <= full_q;
			byp_s1    <= (lag_mod_q == '0);
			lagok_s1  <= lag_ok;
		end
	end

endmodule

/* design/dtc_cmdq.sv */
// -----------------------------------------------------------------------------
// dtc_cmdq
// Two-entry queue of window dump commands between the front and the back.
// -----------------------------------------------------------------------------
module dtc_cmdq
	import dtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  win_cmd_t push_cmd,
	input  logic     pop,
	output logic     q_valid,
	output logic     q_full,
	output win_cmd_t q_head
);

	win_cmd_t   ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign q_valid = (cnt_q != 2'd0);
	assign q_full  = (cnt_q == 2'd2);
	assign q_head  = ent_q[rptr_q];

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store the command
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

endmodule

/* design/dtc_back.sv */
// -----------------------------------------------------------------------------
// dtc_back
// Window readout: walks the ring from the window base, one read per cycle while
// its two-word output buffer has room; the buffer decouples it from the sink.
// -----------------------------------------------------------------------------
module dtc_back
	import dtc_pkg::*;
#(
	parameter int RING_DEPTH = 8192
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// window command queue
	input  logic                          q_valid,
	input  win_cmd_t                      q_head,
	output logic                          q_pop,
	// ring window read
	output logic                          rb_en,
	output logic [$clog2(RING_DEPTH)-1:0] rb_addr,
	input  logic [SAMPLE_W-1:0]           rb_data,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [TDATA_W-1:0]            m_tdata,
	output logic                          m_tlast
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH = (AW+1)'(RING_DEPTH);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH) begin
			s = s - DEPTH;
		end
		return s[AW-1:0];
	endfunction

	logic [KPOS_W-1:0] k_q;
	logic [AW-1:0]     idx;
	logic              idx_hit;
	logic              is_last;
	logic [1:0]        occ;
	logic              pop;
	logic              push;
	logic              issue;

	// Read stage
	logic              rd_v_s1;
	logic [KPOS_W-1:0] rd_k_s1;
	logic              rd_last_s1;
	logic              rd_hit_s1;

	// Output buffer
	out_word_t  obuf_q [2];
	out_word_t  push_word;
	out_word_t  head;
	logic       owptr_q;
	logic       orptr_q;
	logic [1:0] ocnt_q;

	// Address and validity of the next window word
	always_comb begin
		idx     = wrap_add(q_head.base[AW-1:0], AW'(k_q));
		idx_hit = q_head.full_e || (idx != '0 && idx <= q_head.wp_e[AW-1:0]);
		is_last = ({1'b0, k_q} == q_head.win - 1'b1);
		pop     = m_tvalid && m_tready;
		push    = rd_v_s1;
		occ     = ocnt_q + {1'b0, rd_v_s1};
		issue   = q_valid && ((occ - {1'b0, pop}) < 2'd2);
		q_pop   = issue && is_last;
	end

	assign rb_en   = issue;
	assign rb_addr = idx;

	// Word being returned by the ring; unwritten entries read as zero
	always_comb begin
		push_word.value = rd_hit_s1 ? rb_data : '0;
		push_word.pos   = rd_k_s1;
		push_word.last  = rd_last_s1;
	end

	assign head     = obuf_q[orptr_q];
	assign m_tvalid = (ocnt_q != 2'd0);
	assign m_tdata  = {(TDATA_W - SAMPLE_W - KPOS_W)'(0), head.pos, head.value};
	assign m_tlast  = head.last;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (issue) begin
				k_q <= is_last ? '0 : k_q + 1'b1;
			end
			rd_v_s1 <= issue;
			if (push) begin
				owptr_q <= ~owptr_q;
			end
			if (pop) begin
				orptr_q <= ~orptr_q;
			end
			ocnt_q <= ocnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_k_s1    <= k_q;
			rd_last_s1 <= is_last;
			rd_hit_s1  <= idx_hit;
		end
	end

	// Hold returned words until taken
	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[owptr_q] <= push_word;
		end
	end

endmodule

/* design/dtc_checker.sv */
// -----------------------------------------------------------------------------
// dtc_checker
// Port-level checks on the trigger capture block: result stream handshake,
// window numbering and no output before any sample.
// -----------------------------------------------------------------------------
module dtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	logic [5:0] exp_pos_q;
	logic       seen_q;

	// Track expected window position and whether any sample came in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				exp_pos_q <= m_tlast ? '0 : m_tdata[21:16] + 1'b1;
			end
			if (s_tvalid && s_tready) begin
				seen_q <= 1'b1;
			end
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped before it was taken");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result word changed");

	a_pos_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[21:16] == exp_pos_q)
		else $error("window position out of sequence");

	a_no_output_before_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("result word before any sample was accepted");

endmodule

bind differential_trigger_capture_top dtc_checker u_dtc_checker (.*);
